// File: rtl/spjq_pkg.sv
// Package for the sorted priority job queue: item layouts, status codes,
// controller states and the command and status groups between controller and datapath.
// Depends on nothing.
package spjq_pkg;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_POP    = 1'b1;

    localparam logic [1:0] STATUS_DONE       = 2'd0;
    localparam logic [1:0] STATUS_FULL_REJ   = 2'd1;
    localparam logic [1:0] STATUS_EMPTY_REJ  = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [15:0] seq_number;
        logic [7:0]  producer;
        logic [3:0]  urgency;
        logic [3:0]  duration;
        logic [16:0] tag;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        job_valid;
        logic [15:0] out_seq_number;
        logic [7:0]  out_producer;
        logic [3:0]  out_urgency;
        logic [3:0]  out_duration;
        logic [16:0] out_tag;
        logic [4:0]  occupancy;
        logic        empty_flag;
        logic        full_flag;
    } result_t;

    typedef struct packed {
        logic [15:0] seq_number;
        logic [7:0]  producer;
        logic [3:0]  urgency;
        logic [3:0]  duration;
        logic [16:0] tag;
    } job_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INS_STEP,
        ST_INS_CMP,
        ST_POP_OUT
    } state_t;

    typedef struct packed {
        logic load_job;
        logic rd_head;
        logic rd_prev;
        logic shift;
        logic place;
        logic pop_finish;
        logic reject_full;
        logic reject_empty;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic pos_zero;
        logic shift_needed;
    } status_t;

endpackage

// File: rtl/spjq_controller.sv
// Controller state machine for the sorted priority job queue.
// Depends on spjq_pkg for the state, command and status types.
module spjq_controller
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              kind,
    input  spjq_pkg::status_t status,
    output logic              busy,
    output spjq_pkg::cmd_t    cmd
);

    spjq_pkg::state_t state_reg;
    spjq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spjq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spjq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (kind == spjq_pkg::KIND_INSERT)
                    begin
                        if (!status.full)
                        begin
                            state_next = spjq_pkg::ST_INS_STEP;
                        end
                    end
                    else if (!status.empty)
                    begin
                        state_next = spjq_pkg::ST_POP_OUT;
                    end
                end
            end
            spjq_pkg::ST_INS_STEP:
            begin
                state_next = status.pos_zero ? spjq_pkg::ST_IDLE : spjq_pkg::ST_INS_CMP;
            end
            spjq_pkg::ST_INS_CMP:
            begin
                state_next = status.shift_needed ? spjq_pkg::ST_INS_STEP : spjq_pkg::ST_IDLE;
            end
            spjq_pkg::ST_POP_OUT:
            begin
                state_next = spjq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = spjq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            spjq_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (kind == spjq_pkg::KIND_INSERT)
                    begin
                        cmd.load_job    = !status.full;
                        cmd.reject_full = status.full;
                    end
                    else
                    begin
                        cmd.rd_head      = !status.empty;
                        cmd.reject_empty = status.empty;
                    end
                end
            end
            spjq_pkg::ST_INS_STEP:
            begin
                cmd.place   = status.pos_zero;
                cmd.rd_prev = !status.pos_zero;
            end
            spjq_pkg::ST_INS_CMP:
            begin
                cmd.shift = status.shift_needed;
                cmd.place = !status.shift_needed;
            end
            spjq_pkg::ST_POP_OUT:
            begin
                cmd.pop_finish = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/spjq_datapath.sv
// Datapath for the sorted priority job queue: the circular job memory, its
// pointers and count, the walking insert position and the result register.
// Depends on spjq_pkg for the item, job, command and status types.
module spjq_datapath
#(
    parameter int DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  spjq_pkg::request_t request,
    input  spjq_pkg::cmd_t     cmd,
    output spjq_pkg::status_t  status,
    output spjq_pkg::result_t  result,
    output logic               done
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    spjq_pkg::job_t mem [DEPTH];

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] pos_reg, pos_next;
    spjq_pkg::job_t    job_reg, job_next;
    spjq_pkg::job_t    rd_data_reg;
    spjq_pkg::result_t result_reg, result_next;
    logic              done_reg, done_next;

    logic [AW-1:0]  prev_ptr;
    logic [AW-1:0]  head_inc;
    logic [AW-1:0]  tail_inc;
    logic           mem_we;
    logic           mem_re;
    logic [AW-1:0]  mem_raddr;
    spjq_pkg::job_t mem_wdata;

    assign prev_ptr  = (wr_ptr_reg == '0) ? LAST : wr_ptr_reg - 1'b1;
    assign head_inc  = (head_reg == LAST) ? '0 : head_reg + 1'b1;
    assign tail_inc  = (tail_reg == LAST) ? '0 : tail_reg + 1'b1;
    assign mem_we    = cmd.shift | cmd.place;
    assign mem_wdata = cmd.shift ? rd_data_reg : job_reg;
    assign mem_re    = cmd.rd_head | cmd.rd_prev;
    assign mem_raddr = cmd.rd_head ? head_reg : prev_ptr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_ptr_reg] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign status.full         = (count_reg == FULL_COUNT);
    assign status.empty        = (count_reg == '0);
    assign status.pos_zero     = (pos_reg == '0);
    assign status.shift_needed = (rd_data_reg.urgency > job_reg.urgency);

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        job_next    = job_reg;
        result_next = result_reg;
        done_next   = 1'b0;

        if (cmd.load_job)
        begin
            job_next.seq_number = request.seq_number;
            job_next.producer   = request.producer;
            job_next.urgency    = request.urgency;
            job_next.duration   = request.duration;
            job_next.tag        = request.tag;
            wr_ptr_next         = tail_reg;
            pos_next            = count_reg;
        end

        if (cmd.shift)
        begin
            wr_ptr_next = prev_ptr;
            pos_next    = pos_reg - 1'b1;
        end

        if (cmd.place)
        begin
            tail_next  = tail_inc;
            count_next = count_reg + 1'b1;
        end

        if (cmd.pop_finish)
        begin
            head_next  = head_inc;
            count_next = count_reg - 1'b1;
        end

        if (cmd.place || cmd.pop_finish || cmd.reject_full || cmd.reject_empty)
        begin
            done_next   = 1'b1;
            result_next = '0;
            if (cmd.reject_full)
            begin
                result_next.status = spjq_pkg::STATUS_FULL_REJ;
            end
            else if (cmd.reject_empty)
            begin
                result_next.status = spjq_pkg::STATUS_EMPTY_REJ;
            end
            else
            begin
                result_next.status = spjq_pkg::STATUS_DONE;
            end
            if (cmd.pop_finish)
            begin
                result_next.job_valid      = 1'b1;
                result_next.out_seq_number = rd_data_reg.seq_number;
                result_next.out_producer   = rd_data_reg.producer;
                result_next.out_urgency    = rd_data_reg.urgency;
                result_next.out_duration   = rd_data_reg.duration;
                result_next.out_tag        = rd_data_reg.tag;
            end
            result_next.occupancy  = 5'(count_next);
            result_next.empty_flag = (count_next == '0);
            result_next.full_flag  = (count_next == FULL_COUNT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_ptr_reg <= wr_ptr_next;
        pos_reg    <= pos_next;
        job_reg    <= job_next;
        result_reg <= result_next;
    end

    assign result = result_reg;
    assign done   = done_reg;

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("Queue count exceeds the depth.");

    a_place_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.place |=> (count_reg == $past(count_reg) + 1'b1) && done)
        else $error("Placing an item did not grow the queue by one.");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_finish |=> (count_reg == $past(count_reg) - 1'b1) && done
            && result.job_valid)
        else $error("Popping an item did not shrink the queue by one.");

    a_job_means_done: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.job_valid) |-> (result.status == spjq_pkg::STATUS_DONE))
        else $error("A returned job carries a rejection status.");

endmodule

// File: rtl/sorted_priority_job_queue.sv
// Bounded sorted priority queue of job records, kept in ascending urgency
// with equal urgencies in arrival order. An item is taken when start is high
// while busy is low; its result is shown for one cycle with done high and
// cannot be held off. A rejected item keeps busy low and its result follows
// in the next cycle. A pop keeps busy high for one cycle. An insert walks
// back from the tail of the job memory, reading each entry in ST_INS_STEP
// and, in ST_INS_CMP, moving it back one place while its urgency number is
// higher, until it reaches the head or an entry of lower or equal number.
// The result comes in the same cycle in which busy falls.
// Depends on spjq_pkg, spjq_controller and spjq_datapath.
module sorted_priority_job_queue
#(
    parameter int DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  spjq_pkg::request_t request,
    output logic               busy,
    output logic               done,
    output spjq_pkg::result_t  result
);

    spjq_pkg::cmd_t    cmd;
    spjq_pkg::status_t status;

    spjq_controller u_controller
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (request.kind),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    spjq_datapath
    #(
        .DEPTH (DEPTH)
    )
    u_datapath
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .status  (status),
        .result  (result),
        .done    (done)
    );

endmodule
